// File: rtl/mf3_pkg.sv
`timescale 1ns / 1ps
package mf3_pkg;

    // Field widths fixed by the pixel stream format
    localparam int unsigned WIDTH_W = 11;
    localparam int unsigned COL_W   = 10;
    localparam int unsigned ROW_W   = 12;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;

    // Operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Job queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_CW    = 3;

    typedef logic [23:0]      t_pix;
    typedef logic [8:0][23:0] t_win;   // index = row*3 + col
    typedef logic [8:0][7:0]  t_b9;

    // One emitting position: window snapshot plus where it goes
    typedef struct packed {
        t_win             win;
        logic             interior;
        logic             two;       // row end: second pixel follows
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_job;

    // Compare-exchange: smaller value ends at a
    function automatic t_b9 cs(t_b9 p, logic [3:0] a, logic [3:0] b);
        t_b9 r;
        r = p;
        if (p[a] > p[b]) begin
            r[a] = p[b];
            r[b] = p[a];
        end
        return r;
    endfunction

    // Median-of-nine network, first half (three levels)
    function automatic t_b9 sort_a(t_b9 p);
        t_b9 r;
        r = cs(p, 4'd1, 4'd2);
        r = cs(r, 4'd4, 4'd5);
        r = cs(r, 4'd7, 4'd8);
        r = cs(r, 4'd0, 4'd1);
        r = cs(r, 4'd3, 4'd4);
        r = cs(r, 4'd6, 4'd7);
        r = cs(r, 4'd1, 4'd2);
        r = cs(r, 4'd4, 4'd5);
        r = cs(r, 4'd7, 4'd8);
        return r;
    endfunction

    // Median-of-nine network, second half
    function automatic logic [7:0] sort_b(t_b9 p);
        t_b9 r;
        r = cs(p, 4'd0, 4'd3);
        r = cs(r, 4'd5, 4'd8);
        r = cs(r, 4'd4, 4'd7);
        r = cs(r, 4'd3, 4'd6);
        r = cs(r, 4'd1, 4'd4);
        r = cs(r, 4'd2, 4'd5);
        r = cs(r, 4'd4, 4'd7);
        r = cs(r, 4'd4, 4'd2);
        r = cs(r, 4'd6, 4'd4);
        r = cs(r, 4'd4, 4'd2);
        return r[4];
    endfunction

endpackage

// File: rtl/mf3_if.sv
`timescale 1ns / 1ps

// Pixel input channel
interface mf3_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, operation, blue, green, red, input ready);
    modport sink   (input valid, operation, blue, green, red, output ready);
endinterface

// Result channel
interface mf3_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
    modport source (output valid, out_blue, out_green, out_red, out_row, out_col,
                    last_of_run, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, out_row, out_col,
                    last_of_run, output ready);
endinterface

// Width register write channel
interface mf3_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/mf3_ram.sv
`timescale 1ns / 1ps
module mf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/mf3_front.sv
`timescale 1ns / 1ps
module mf3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mf3_cfg_if.sink                    i_cfg,
    mf3_in_if.sink                     i_pix,
    input  logic [mf3_pkg::Q_CW-1:0]   i_q_count,
    output logic                       o_push,
    output mf3_pkg::t_job              o_job
);
    import mf3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

    logic [WIDTH_W-1:0] r_width;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [1:0]         r_filled;
    t_win               r_win;

    logic               r_s1_v;
    t_pix               r_s1_pix;
    logic [AW-1:0]      r_s1_addr;
    logic               r_s1_inr;
    logic               r_s1_emit;
    logic               r_s1_int;
    logic               r_s1_two;
    logic [ROW_W-1:0]   r_s1_row;
    logic [COL_W-1:0]   r_s1_col;

    logic          accept;
    logic [WW-1:0] c_ext;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] wv_ext;
    logic          last_col;
    logic          emit;
    logic          interior;
    logic          inr;
    logic [47:0]   rdata;
    t_pix          top;
    t_pix          mid;
    t_pix          pix;
    t_win          n_win;

    // Width register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_width <= i_cfg.data;
        end
    end

    // Credit check: leave room for the transaction in stage 1
    assign i_pix.ready = r_s1_v ? (i_q_count < Q_CW'(Q_DEPTH - 1))
                                : (i_q_count < Q_CW'(Q_DEPTH));
    assign accept = i_pix.valid && i_pix.ready;
    assign pix    = {i_pix.red, i_pix.green, i_pix.blue};

    // Classify the position
    always_comb begin
        c_ext  = WW'(r_col);
        wv_ext = WW'(r_width);
        if (wv_ext < WW'(3)) begin
            w_eff = WW'(3);
        end else if (wv_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = wv_ext;
        end
        last_col = c_ext >= (w_eff - WW'(1));
        inr      = c_ext < WW'(MAX_WIDTH);
        emit     = (r_filled != 2'd0) && (r_col != '0);
        interior = (r_filled == 2'd2) && (i_pix.operation != OP_FLUSH)
                   && (r_col >= COL_W'(2)) && (c_ext <= (w_eff - WW'(1)));
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_filled <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                if (i_pix.operation == OP_FLUSH) begin
                    r_row    <= '0;
                    r_filled <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                    if (r_filled != 2'd2) begin
                        r_filled <= r_filled + 2'd1;
                    end
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= pix;
            r_s1_addr <= c_ext[AW-1:0];
            r_s1_inr  <= inr;
            r_s1_emit <= emit;
            r_s1_int  <= interior;
            r_s1_two  <= last_col;
            r_s1_row  <= r_row - ROW_W'(1);
            r_s1_col  <= r_col - COL_W'(1);
        end
    end

    // Line stores: {older, newer} per column
    mf3_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_s1_v && r_s1_inr),
        .i_waddr (r_s1_addr),
        .i_wdata ({mid, r_s1_pix}),
        .i_re    (accept && inr),
        .i_raddr (c_ext[AW-1:0]),
        .o_rdata (rdata)
    );

    // Window shift
    always_comb begin
        top = r_s1_inr ? rdata[47:24] : '0;
        mid = r_s1_inr ? rdata[23:0]  : '0;
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = top;
        n_win[5] = mid;
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_win <= n_win;
        end
    end

    assign o_push       = r_s1_v && r_s1_emit;
    assign o_job.win      = n_win;
    assign o_job.interior = r_s1_int;
    assign o_job.two      = r_s1_two;
    assign o_job.row      = r_s1_row;
    assign o_job.col      = r_s1_col;
endmodule

// File: rtl/mf3_queue.sv
`timescale 1ns / 1ps
module mf3_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  mf3_pkg::t_job             i_job,
    input  logic                      i_pop,
    output logic                      o_valid,
    output mf3_pkg::t_job             o_job,
    output logic [mf3_pkg::Q_CW-1:0]  o_count
);
    import mf3_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic            pop;

    assign pop = i_pop && (r_count != '0);

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rp];
    assign o_count = r_count;
endmodule

// File: rtl/mf3_back.sv
`timescale 1ns / 1ps
module mf3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mf3_pkg::t_job  i_job,
    output logic           o_pop,
    mf3_out_if.source      o_pix
);
    import mf3_pkg::*;

    // Stage A: first half of the sort network
    logic             r_a_v;
    t_win             r_a_part;
    t_pix             r_a_center;
    t_pix             r_a_second;
    logic             r_a_int;
    logic             r_a_two;
    logic [ROW_W-1:0] r_a_row;
    logic [COL_W-1:0] r_a_col;

    // Output register
    logic             r_o_v;
    logic             r_o_phase;
    t_pix             r_o_pix;
    t_pix             r_o_second;
    logic             r_o_two;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;

    logic out_take;
    logic out_done;
    logic o_free;
    logic a_free;
    t_win part;
    t_pix med;
    t_pix out_pix;

    assign out_take = o_pix.valid && o_pix.ready;
    assign out_done = out_take && (r_o_phase || !r_o_two);
    assign o_free   = !r_o_v || out_done;
    assign a_free   = !r_a_v || o_free;
    assign o_pop    = i_valid && a_free;

    // Per-channel partial sort
    always_comb begin
        t_b9 b;
        t_b9 s;
        part = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int n = 0; n < 9; n++) begin
                b[n] = i_job.win[n][ch*8 +: 8];
            end
            s = sort_a(b);
            for (int n = 0; n < 9; n++) begin
                part[n][ch*8 +: 8] = s[n];
            end
        end
    end

    // Per-channel median pick
    always_comb begin
        t_b9 b;
        med = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int n = 0; n < 9; n++) begin
                b[n] = r_a_part[n][ch*8 +: 8];
            end
            med[ch*8 +: 8] = sort_b(b);
        end
    end

    // Valid flags and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_o_v     <= 1'b0;
            r_o_phase <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_v <= i_valid;
            end
            if (o_free) begin
                r_o_v     <= r_a_v;
                r_o_phase <= 1'b0;
            end else if (out_take) begin
                r_o_phase <= 1'b1;
            end
        end
    end

    // Stage A payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_part   <= part;
            r_a_center <= i_job.win[4];
            r_a_second <= i_job.win[5];
            r_a_int    <= i_job.interior;
            r_a_two    <= i_job.two;
            r_a_row    <= i_job.row;
            r_a_col    <= i_job.col;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_free && r_a_v) begin
            r_o_pix    <= r_a_int ? med : r_a_center;
            r_o_second <= r_a_second;
            r_o_two    <= r_a_two;
            r_o_row    <= r_a_row;
            r_o_col    <= r_a_col;
        end
    end

    // Row end sends the last column as a second transaction
    assign out_pix           = r_o_phase ? r_o_second : r_o_pix;
    assign o_pix.valid       = r_o_v;
    assign o_pix.out_blue    = out_pix[7:0];
    assign o_pix.out_green   = out_pix[15:8];
    assign o_pix.out_red     = out_pix[23:16];
    assign o_pix.out_row     = r_o_row;
    assign o_pix.out_col     = r_o_phase ? (r_o_col + COL_W'(1)) : r_o_col;
    assign o_pix.last_of_run = r_o_phase || !r_o_two;
endmodule

// File: rtl/median_filter_3x3_rgb_top.sv
// Path: stage 1 register, job queue, stage A of the sort network, output register.
// Throughput: one pixel per cycle while the job queue has room and the output is not stalled;
// the last column of a row emits two output transactions (absorbed by a 4-entry job queue).
// Reset (synchronous, active low): counters clear, image width returns to 640;
// line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module median_filter_3x3_rgb_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mf3_cfg_if.sink    i_cfg,
    mf3_in_if.sink     i_pix,
    mf3_out_if.source  o_pix
);
    import mf3_pkg::*;

    logic            push;
    t_job            push_job;
    logic            q_valid;
    t_job            q_job;
    logic            pop;
    logic [Q_CW-1:0] q_count;

    // Window and line-store front end
    mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_pix     (i_pix),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (push_job)
    );

    mf3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    // Median network and output
    mf3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );
endmodule

// File: test/mf3_checker.sv
`timescale 1ns / 1ps
module mf3_checker
    import mf3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mf3_cfg_if    cfg,
    mf3_in_if     pix,
    mf3_out_if    res,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_result_count
);

    localparam int LINE_DEPTH = 1024;

    typedef struct {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_filt_pix;

    // Predictor state
    t_pix             line_old [LINE_DEPTH];
    t_pix             line_new [LINE_DEPTH];
    t_pix             win [3][3];
    logic [COL_W-1:0] col_cnt;
    logic [ROW_W-1:0] row_cnt;
    logic [1:0]       rows_done;
    logic [WIDTH_W-1:0] width_reg;
    t_filt_pix        expected_q[$];

    // Median of the nine window bytes at bit offset sh
    function automatic logic [7:0] win_median(int sh);
        logic [7:0] v [9];
        logic [7:0] x;
        int j;
        for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3][sh +: 8];
        for (int i = 1; i < 9; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[4];
    endfunction

    function automatic void push_pix(t_pix p, logic [COL_W-1:0] c, logic last);
        t_filt_pix e;
        e.blue  = p[7:0];
        e.green = p[15:8];
        e.red   = p[23:16];
        e.row   = row_cnt - 1'b1;
        e.col   = c;
        e.last  = last;
        expected_q = {expected_q, e};
    endfunction

    // Advance the filter by one input transaction
    function automatic void filter_step(logic op, t_pix p);
        int unsigned w, c;
        t_pix top, mid, val;
        logic last_col, interior;
        top = '0;
        mid = '0;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        c = col_cnt;
        last_col = (c >= w - 1);
        if (c < LINE_DEPTH) begin
            top = line_old[c];
            mid = line_new[c];
            line_old[c] = mid;
            line_new[c] = p;
        end
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = p;

        if (rows_done >= 1 && c >= 1) begin
            interior = rows_done >= 2 && op == OP_PIXEL && c >= 2 && c <= w - 1;
            val = win[1][1];
            if (interior) val = {win_median(16), win_median(8), win_median(0)};
            push_pix(val, COL_W'(c - 1), !last_col);
            if (last_col) push_pix(win[1][2], COL_W'(c), 1'b1);
        end

        if (last_col) begin
            col_cnt = '0;
            if (op == OP_FLUSH) begin
                row_cnt   = '0;
                rows_done = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
                if (rows_done < 2) rows_done++;
            end
        end else begin
            col_cnt = COL_W'(c + 1);
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_filt_pix e;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) win[i][j] = '0;
            col_cnt        = '0;
            row_cnt        = '0;
            rows_done      = '0;
            width_reg      = WIDTH_RESET;
            o_fail_count   = 0;
            o_result_count = 0;
            expected_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) width_reg = cfg.data;
            if (pix.valid && pix.ready)
                filter_step(pix.operation, {pix.red, pix.green, pix.blue});
            if (res.valid && res.ready) begin
                o_result_count++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction at row %0d col %0d",
                           res.out_row, res.out_col);
                    o_fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("out_blue", int'(e.blue), int'(res.out_blue));
                    check_field("out_green", int'(e.green), int'(res.out_green));
                    check_field("out_red", int'(e.red), int'(res.out_red));
                    check_field("out_row", int'(e.row), int'(res.out_row));
                    check_field("out_col", int'(e.col), int'(res.out_col));
                    check_field("last_of_run", int'(e.last), int'(res.last_of_run));
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mf3_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1150;

    logic i_clk;
    logic i_rst_n;

    mf3_cfg_if cfg_if ();
    mf3_in_if  in_if ();
    mf3_out_if out_if ();

    median_filter_3x3_rgb_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (in_if),
        .o_pix   (out_if)
    );

    int fail_count, pending, result_count;

    mf3_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .cfg            (cfg_if),
        .pix            (in_if),
        .res            (out_if),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stimulus-side view of where the row stands
    int unsigned eff_width;
    int unsigned col_pos;
    int          pix_sent;
    bit          calm;       // no gaps, no stalls
    bit          hold_req;   // receiver: one long hold-off

    // Watchdog on cycles with no transaction at all
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic op, t_pix p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.blue      <= p[7:0];
        in_if.green     <= p[15:8];
        in_if.red       <= p[23:16];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pix_sent++;
        col_pos = (col_pos >= eff_width - 1) ? 0 : col_pos + 1;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] w);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        eff_width = (w < 3) ? 3 : (w > 1024) ? 1024 : w;
    endtask

    // Pixel content: 0 (and any other mode) random, 1 extremes, 2 near-flat with outliers
    function automatic t_pix make_pix(int mode);
        t_pix p;
        case (mode)
            1: begin
                for (int k = 0; k < 24; k += 8) p[k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: begin
                for (int k = 0; k < 24; k += 8)
                    p[k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(120, 124));
            end
            default: p = 24'($urandom);
        endcase
        return p;
    endfunction

    // Close the frame: flush items up to and including the last column
    task automatic end_frame();
        bit was_last;
        do begin
            was_last = (col_pos >= eff_width - 1);
            send_item(OP_FLUSH, 24'($urandom));
        end while (!was_last);
    endtask

    // Whole frame; flush_pct sprinkles stray flush items into the rows
    task automatic send_frame(int rows, int mode, int flush_pct);
        logic op;
        for (int i = 0; i < rows * int'(eff_width); i++) begin
            op = ($urandom_range(0, 99) < flush_pct) ? OP_FLUSH : OP_PIXEL;
            send_item(op, make_pix(mode));
        end
        end_frame();
    endtask

    initial begin
        int w, rows, mode;
        i_rst_n         <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_PIXEL;
        in_if.blue      <= '0;
        in_if.green     <= '0;
        in_if.red       <= '0;
        eff_width = 640;
        col_pos   = 0;
        pix_sent  = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: narrowest frame with extreme channel values
        write_width(11'd3);
        send_item(OP_PIXEL, 24'h000000);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h00FF00);
        send_item(OP_PIXEL, 24'hFF00FF);
        send_item(OP_PIXEL, 24'h000000);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h000000);
        send_item(OP_PIXEL, 24'h7F807F);
        end_frame();
        // Flush in the middle of a row, then a repeated flush row
        send_item(OP_PIXEL, 24'h123456);
        send_item(OP_FLUSH, 24'hABCDEF);
        send_item(OP_PIXEL, 24'hFEDCBA);
        send_frame(3, 1, 0);
        end_frame();

        // Width below range clamps to three
        write_width(11'd0);
        send_frame(3, 0, 0);

        // Width cut mid-row: a row of 8 is cut to end at column 4 once the width drops to 4
        write_width(11'd8);
        for (int i = 0; i < 20; i++) send_item(OP_PIXEL, make_pix(0));
        write_width(11'd4);
        send_frame(3, 0, 0);

        // Random frames
        while (pix_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 2);
                1: w = 3;
                2: w = 4;
                3: w = 5;
                4: w = 64;
                default: w = $urandom_range(6, 40);
            endcase
            write_width(11'(w));
            rows = (w >= 64) ? 3 : $urandom_range(3, 8);
            mode = $urandom_range(0, 3);
            calm = ($urandom_range(0, 5) == 0);
            if (w >= 64 && $urandom_range(0, 1) == 0 && !hold_req) hold_req = 1'b1;
            if ($urandom_range(0, 6) == 0) send_frame(rows, mode, 12);
            else send_frame(rows, mode, 0);
        end
        calm = 1'b0;

        // Receiver blocked for a long stretch while the stream keeps coming
        write_width(11'd32);
        hold_req = 1'b1;
        send_frame(4, 0, 0);

        wait_idle();
        $display("Covered %0d input transactions and %0d results over widths 0..64,",
                 pix_sent, result_count);
        $display("stray flushes, a mid-row width cut and a long output stall.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
